// File: rtl/bso_pkg.sv
package bso_pkg;

  // store geometry
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = 64;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int OFF_W     = $clog2(WORD_BITS);

  // payload widths
  localparam int CMD_W = 3;
  localparam int VAL_W = 12;

  // highest value the store can hold, limited to the value range
  localparam int CAP_M1  = WORD_BITS * NUM_WORDS - 1;
  localparam int VAL_MAX = 2 ** VAL_W - 1;
  localparam logic [VAL_W-1:0] TOP_CAP = VAL_W'((CAP_M1 < VAL_MAX) ? CAP_M1 : VAL_MAX);

  // configuration port
  localparam int CFG_AW = 3;
  localparam int DATA_W = 32;
  localparam logic [CFG_AW-3:0] REG_TOP_VALUE = '0;
  localparam logic [VAL_W-1:0]  TOP_RESET     = VAL_W'(4095);

  // command codes
  localparam logic [CMD_W-1:0] CMD_SET       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TEST      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_RANGE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLR_RANGE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd6;

  typedef struct packed {
    logic load;   // take the input item
    logic step;   // one read-modify-write of the current word
    logic push;   // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic rmw;        // accepted item touches the store word by word
    logic last_word;  // current word is the final one of the item
    logic out_free;   // output register can take a result
  } dp_sts_t;

  function automatic logic [VAL_W-1:0] eff_top(input logic [VAL_W-1:0] top);
    return (top < TOP_CAP) ? top : TOP_CAP;
  endfunction

endpackage

// File: rtl/bso_cmd_if.sv
interface bso_cmd_if;
  logic                     valid;
  logic                     ready;
  logic [bso_pkg::CMD_W-1:0] cmd;
  logic [bso_pkg::VAL_W-1:0] first_value;
  logic [bso_pkg::VAL_W-1:0] last_value;

  modport source (output valid, output cmd, output first_value, output last_value,
                  input ready);
  modport sink (input valid, input cmd, input first_value, input last_value,
                output ready);
endinterface

// File: rtl/bso_res_if.sv
interface bso_res_if;
  logic valid;
  logic ready;
  logic is_member;
  logic ignored;

  modport source (output valid, output is_member, output ignored, input ready);
  modport sink (input valid, input is_member, input ignored, output ready);
endinterface

// File: rtl/bitset_store_with_range_ops.sv
// single-value commands: one word read-modify-write, new item taken once result is pushed
// range commands: each covered word in turn, one word read-modify-write per cycle
// ignored, unused, clear-all: no word written; clear-all drops every word valid bit
// the store is a word-wide memory with one read and one write port (next word read
// while the current one is written)
// reset: per-word valid bits clear at once so the store reads as zero, top_value is 4095
module bitset_store_with_range_ops (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bso_cmd_if.sink                     in_if,
  bso_res_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bso_pkg::CFG_AW-1:0]  paddr,
  input  logic [bso_pkg::DATA_W-1:0]  pwdata,
  output logic [bso_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  logic [bso_pkg::VAL_W-1:0] top_value_q;
  logic                      top_sel;
  bso_pkg::ctrl_cmd_t        ctrl;
  bso_pkg::dp_sts_t          sts;

  assign top_sel = paddr[bso_pkg::CFG_AW-1:2] == bso_pkg::REG_TOP_VALUE;
  assign pready  = 1'b1;
  assign prdata  = top_sel ? bso_pkg::DATA_W'(top_value_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_value_q <= bso_pkg::TOP_RESET;
    end else if (psel && penable && pwrite && top_sel) begin
      top_value_q <= pwdata[bso_pkg::VAL_W-1:0];
    end
  end

  bso_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (ctrl)
  );

  bso_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .top_value_i   (top_value_q),
    .cmd_i         (in_if.cmd),
    .first_value_i (in_if.first_value),
    .last_value_i  (in_if.last_value),
    .ctrl_i        (ctrl),
    .sts_o         (sts),
    .out_ready_i   (out_if.ready),
    .out_valid_o   (out_if.valid),
    .is_member_o   (out_if.is_member),
    .ignored_o     (out_if.ignored)
  );

endmodule

// File: rtl/bso_ctrl.sv
module bso_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bso_pkg::dp_sts_t   sts_i,
  output bso_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.rmw ? ST_MOD : ST_DONE;
        end
      end
      ST_MOD: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_word) begin
          if (sts_i.out_free) begin
            cmd_o.push = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/bso_datapath.sv
module bso_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bso_pkg::VAL_W-1:0]     top_value_i,
  input  logic [bso_pkg::CMD_W-1:0]     cmd_i,
  input  logic [bso_pkg::VAL_W-1:0]     first_value_i,
  input  logic [bso_pkg::VAL_W-1:0]     last_value_i,
  input  bso_pkg::ctrl_cmd_t            ctrl_i,
  output bso_pkg::dp_sts_t              sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          is_member_o,
  output logic                          ignored_o
);

  logic [bso_pkg::WORD_BITS-1:0] mem [bso_pkg::NUM_WORDS];
  logic [bso_pkg::NUM_WORDS-1:0] vld_q;

  logic [bso_pkg::CMD_W-1:0]     op_q;
  logic [bso_pkg::WORD_AW-1:0]   cur_w_q, end_w_q;
  logic [bso_pkg::OFF_W-1:0]     lo_off_q, hi_off_q;
  logic                          first_q, ign_q, member_q;
  logic [bso_pkg::WORD_BITS-1:0] rdata_q;
  logic                          rvld_q;
  logic                          out_valid_q, out_member_q, out_ign_q;

  // decode of the incoming item
  logic [bso_pkg::VAL_W-1:0]   top, lo_v, hi_v, start_v, end_v;
  logic                        is_single, is_range, ign_d;
  logic [bso_pkg::WORD_AW-1:0] start_w, end_w, rd_addr;

  always_comb begin
    top       = bso_pkg::eff_top(top_value_i);
    lo_v      = (first_value_i < last_value_i) ? first_value_i : last_value_i;
    hi_v      = (first_value_i < last_value_i) ? last_value_i : first_value_i;
    is_single = cmd_i inside {bso_pkg::CMD_SET, bso_pkg::CMD_CLEAR, bso_pkg::CMD_TOGGLE,
                              bso_pkg::CMD_TEST};
    is_range  = cmd_i inside {bso_pkg::CMD_SET_RANGE, bso_pkg::CMD_CLR_RANGE};
    if (is_single) begin
      start_v = first_value_i;
      end_v   = first_value_i;
      ign_d   = first_value_i > top;
    end else begin
      start_v = lo_v;
      end_v   = (hi_v > top) ? top : hi_v;
      ign_d   = is_range && (lo_v > top);
    end
    start_w = bso_pkg::WORD_AW'(start_v / bso_pkg::WORD_BITS);
    end_w   = bso_pkg::WORD_AW'(end_v / bso_pkg::WORD_BITS);
  end

  // read-modify-write of the current word
  logic [bso_pkg::WORD_BITS-1:0] base, mask, wdata, ones;
  logic [bso_pkg::OFF_W-1:0]     lo_use, hi_use;
  logic                          last_word, we, member_now;

  always_comb begin
    ones      = '1;
    last_word = cur_w_q == end_w_q;
    lo_use    = first_q ? lo_off_q : '0;
    hi_use    = last_word ? hi_off_q : bso_pkg::OFF_W'(bso_pkg::WORD_BITS - 1);
    mask      = (ones << lo_use) &
                (ones >> (bso_pkg::OFF_W'(bso_pkg::WORD_BITS - 1) - hi_use));
    base      = rvld_q ? rdata_q : '0;
    case (op_q)
      bso_pkg::CMD_SET, bso_pkg::CMD_SET_RANGE:   wdata = base | mask;
      bso_pkg::CMD_CLEAR, bso_pkg::CMD_CLR_RANGE: wdata = base & ~mask;
      bso_pkg::CMD_TOGGLE:                        wdata = base ^ mask;
      default:                                    wdata = base;
    endcase
    we         = ctrl_i.step && (op_q != bso_pkg::CMD_TEST);
    member_now = (op_q == bso_pkg::CMD_TEST) && (|(base & mask));
    // next word is fetched while the current one is written back
    rd_addr    = ctrl_i.step ? cur_w_q + 1'b1 : start_w;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[cur_w_q] <= wdata;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[rd_addr];
      if (ctrl_i.load && (cmd_i == bso_pkg::CMD_CLEAR_ALL)) begin
        vld_q <= '0;
      end else if (we) begin
        vld_q[cur_w_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q     <= cmd_i;
      cur_w_q  <= start_w;
      end_w_q  <= end_w;
      lo_off_q <= bso_pkg::OFF_W'(start_v % bso_pkg::WORD_BITS);
      hi_off_q <= bso_pkg::OFF_W'(end_v % bso_pkg::WORD_BITS);
      first_q  <= 1'b1;
      ign_q    <= ign_d;
      member_q <= 1'b0;
    end else if (ctrl_i.step) begin
      cur_w_q  <= cur_w_q + 1'b1;
      first_q  <= 1'b0;
      member_q <= member_now;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      out_member_q <= ctrl_i.step ? member_now : member_q;
      out_ign_q    <= ign_q;
    end
  end

  assign sts_o.rmw       = (is_single || is_range) && !ign_d;
  assign sts_o.last_word = last_word;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign is_member_o = out_member_q;
  assign ignored_o   = out_ign_q;

endmodule

// File: tb/bitset_store_with_range_ops_tb.sv
module bitset_store_with_range_ops_tb;
  import bso_pkg::*;

  localparam int                  CYCLE_LIMIT = 1_000_000;
  localparam logic [CMD_W-1:0]    CMD_UNUSED  = 3'd7;
  localparam logic [CFG_AW-1:0]   TOP_ADDR    = {REG_TOP_VALUE, 2'b00};
  localparam logic [WORD_BITS-1:0] ALL_ONES   = '1;

  typedef struct packed {
    logic is_member;
    logic ignored;
  } bso_result_t;

  // mirror of the bit store plus the queue of results still owed by the block
  class bitset_scoreboard;
    logic [WORD_BITS-1:0] words [NUM_WORDS];
    logic [VAL_W-1:0]     top_value;
    bso_result_t          result_q[$];
    int                   errors;
    int                   checked;

    function new();
      foreach (words[i]) words[i] = '0;
      top_value = TOP_RESET;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_top(logic [VAL_W-1:0] v);
      top_value = v;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function void note_cmd(logic [CMD_W-1:0] cmd, logic [VAL_W-1:0] first_v,
                           logic [VAL_W-1:0] last_v);
      int                   cap, reach, lo, hi, w0, w1, lb, hb;
      logic [WORD_BITS-1:0] bit_m, mask;
      bso_result_t          r;
      cap   = WORD_BITS * NUM_WORDS - 1;
      reach = (int'(top_value) < cap) ? int'(top_value) : cap;
      r     = '0;
      case (cmd)
        CMD_SET, CMD_CLEAR, CMD_TOGGLE, CMD_TEST: begin
          lo = int'(first_v);
          if (lo > reach) begin
            r.ignored = 1'b1;
          end else begin
            w0 = lo / WORD_BITS;
            bit_m = '0;
            bit_m[lo % WORD_BITS] = 1'b1;
            if (cmd == CMD_SET) words[w0] |= bit_m;
            else if (cmd == CMD_CLEAR) words[w0] &= ~bit_m;
            else if (cmd == CMD_TOGGLE) words[w0] ^= bit_m;
            else r.is_member = |(words[w0] & bit_m);
          end
        end
        CMD_SET_RANGE, CMD_CLR_RANGE: begin
          lo = (first_v < last_v) ? int'(first_v) : int'(last_v);
          hi = (first_v < last_v) ? int'(last_v) : int'(first_v);
          if (lo > reach) begin
            r.ignored = 1'b1;
          end else begin
            if (hi > reach) hi = reach;
            w0 = lo / WORD_BITS;
            w1 = hi / WORD_BITS;
            for (int w = w0; w <= w1; w++) begin
              lb   = (w == w0) ? lo % WORD_BITS : 0;
              hb   = (w == w1) ? hi % WORD_BITS : WORD_BITS - 1;
              mask = (ALL_ONES >> (WORD_BITS - 1 - hb)) & (ALL_ONES << lb);
              if (cmd == CMD_SET_RANGE) words[w] |= mask;
              else words[w] &= ~mask;
            end
          end
        end
        CMD_CLEAR_ALL: begin
          foreach (words[i]) words[i] = '0;
        end
        default: ;
      endcase
      result_q.push_back(r);
    endfunction

    function void check_result(logic got_member, logic got_ignored);
      bso_result_t want;
      checked++;
      if (result_q.size() == 0) begin
        errors++;
        $display("%0t: result %0d with none expected (is_member %b ignored %b)",
                 $time, checked, got_member, got_ignored);
        return;
      end
      want = result_q.pop_front();
      if (got_member !== want.is_member) begin
        errors++;
        $display("%0t: result %0d is_member expected %b actual %b",
                 $time, checked, want.is_member, got_member);
      end
      if (got_ignored !== want.ignored) begin
        errors++;
        $display("%0t: result %0d ignored expected %b actual %b",
                 $time, checked, want.ignored, got_ignored);
      end
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              recv_ready = 1'b0;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [CFG_AW-1:0] paddr      = '0;
  logic [DATA_W-1:0] pwdata     = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                send_idle  = 0;
  int                recv_stall = 0;
  int                win_base   = 0;
  int                cycle_count = 0;
  bitset_scoreboard  store_sb;

  bso_cmd_if cmd_if();
  bso_res_if res_if();

  assign res_if.ready = recv_ready;

  bitset_store_with_range_ops uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_if   (cmd_if),
    .out_if  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bitset_store_with_range_ops_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && recv_ready) begin
      store_sb.check_result(res_if.is_member, res_if.ignored);
    end
    recv_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_cmd(logic [CMD_W-1:0] c, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    while ($urandom_range(99) < send_idle) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= c;
    cmd_if.first_value <= a;
    cmd_if.last_value  <= b;
    do @(posedge clk); while (!cmd_if.ready);
    store_sb.note_cmd(c, a, b);
  endtask

  // hold the input side until every owed result has come back
  task automatic drain();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (store_sb.pending() > 0);
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_AW-1:0] addr,
                          input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_top();
    logic [DATA_W-1:0] rd;
    apb_xfer(1'b0, TOP_ADDR, '0, rd);
    if (rd !== DATA_W'(store_sb.top_value)) begin
      store_sb.errors++;
      $display("%0t: top_value read expected %0d actual %0d",
               $time, store_sb.top_value, rd);
    end
  endtask

  task automatic set_top(logic [VAL_W-1:0] v);
    logic [DATA_W-1:0] rd;
    drain();
    apb_xfer(1'b1, TOP_ADDR, DATA_W'(v), rd);
    store_sb.set_top(v);
    check_top();
  endtask

  function automatic logic [VAL_W-1:0] pick_value(int reach);
    int r, v;
    r = $urandom_range(99);
    if (r < 40) v = win_base + $urandom_range(127);
    else if (r < 70) v = $urandom_range(reach);
    else if (r < 90) v = $urandom_range(VAL_MAX);
    else begin
      case ($urandom_range(3))
        0: v = 0;
        1: v = reach;
        2: v = reach + 1;
        default: v = VAL_MAX;
      endcase
    end
    if (v > VAL_MAX) v = VAL_MAX;
    return VAL_W'(v);
  endfunction

  initial begin
    int                i, r, d, v, reach;
    logic [CMD_W-1:0]  c;
    logic [VAL_W-1:0]  a, b, new_top;
    cmd_if.valid       <= 1'b0;
    cmd_if.cmd         <= CMD_SET;
    cmd_if.first_value <= '0;
    cmd_if.last_value  <= '0;
    store_sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    check_top();
    set_top(VAL_W'(4095));

    // directed: extremes, word edges, reversed ranges, clamping, lowered top
    send_cmd(CMD_SET, 12'd0, 12'd0);
    send_cmd(CMD_SET, 12'd4095, 12'd4095);
    send_cmd(CMD_TEST, 12'd0, 12'd4095);
    send_cmd(CMD_TEST, 12'd4095, 12'd0);
    send_cmd(CMD_TOGGLE, 12'd63, 12'd0);
    send_cmd(CMD_TOGGLE, 12'd64, 12'd0);
    send_cmd(CMD_TEST, 12'd64, 12'd0);
    send_cmd(CMD_CLEAR, 12'd0, 12'd0);
    send_cmd(CMD_SET_RANGE, 12'd4095, 12'd0);
    send_cmd(CMD_TEST, 12'd2000, 12'd0);
    send_cmd(CMD_CLR_RANGE, 12'd130, 12'd10);
    send_cmd(CMD_TEST, 12'd9, 12'd0);
    send_cmd(CMD_TEST, 12'd70, 12'd0);
    send_cmd(CMD_CLEAR_ALL, 12'd0, 12'd0);
    send_cmd(CMD_SET, 12'd3000, 12'd0);
    send_cmd(CMD_UNUSED, 12'd4095, 12'd4095);
    set_top(VAL_W'(100));
    send_cmd(CMD_SET, 12'd200, 12'd0);
    send_cmd(CMD_TEST, 12'd3000, 12'd0);
    send_cmd(CMD_SET_RANGE, 12'd4000, 12'd150);
    send_cmd(CMD_SET_RANGE, 12'd4000, 12'd50);
    send_cmd(CMD_TOGGLE, 12'd101, 12'd0);
    send_cmd(CMD_CLR_RANGE, 12'd100, 12'd100);
    set_top(VAL_W'(0));
    send_cmd(CMD_SET_RANGE, 12'd0, 12'd4095);
    set_top(VAL_W'(4095));
    send_cmd(CMD_TEST, 12'd3000, 12'd0);
    send_cmd(CMD_TEST, 12'd101, 12'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          new_top = VAL_W'(4095); send_idle = 0; recv_stall = 0;
        end
        1: begin
          new_top = VAL_W'($urandom_range(4095, 64)); send_idle = 66; recv_stall = 0;
        end
        2: begin
          // top on a word edge or just below it
          new_top = VAL_W'(64 * $urandom_range(63, 1) - $urandom_range(1));
          send_idle = 0; recv_stall = 66;
        end
        default: begin
          new_top = VAL_W'($urandom_range(300)); send_idle = 33; recv_stall = 33;
        end
      endcase
      set_top(new_top);
      reach    = int'(new_top);
      win_base = $urandom_range(reach);
      for (i = 0; i < 150; i++) begin
        if (i == 75) drain();
        r = $urandom_range(99);
        if (r < 15) c = CMD_SET;
        else if (r < 25) c = CMD_CLEAR;
        else if (r < 35) c = CMD_TOGGLE;
        else if (r < 65) c = CMD_TEST;
        else if (r < 77) c = CMD_SET_RANGE;
        else if (r < 87) c = CMD_CLR_RANGE;
        else if (r < 89) c = CMD_CLEAR_ALL;
        else if (r < 92) c = CMD_UNUSED;
        else c = CMD_TEST;
        a = pick_value(reach);
        if ((c == CMD_SET_RANGE || c == CMD_CLR_RANGE) && $urandom_range(99) < 70) begin
          d = $urandom_range(200);
          v = $urandom_range(1) ? int'(a) + d : int'(a) - d;
          if (v < 0) v = 0;
          if (v > VAL_MAX) v = VAL_MAX;
          b = VAL_W'(v);
        end else if (c == CMD_SET_RANGE || c == CMD_CLR_RANGE) begin
          b = pick_value(reach);
        end else begin
          b = VAL_W'($urandom_range(VAL_MAX));
        end
        send_cmd(c, a, b);
      end
    end

    drain();
    repeat (80) @(posedge clk);
    if (store_sb.errors == 0 && store_sb.pending() == 0) begin
      $display("bitset_store_with_range_ops_tb: done, clean");
    end else begin
      $display("bitset_store_with_range_ops_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/bso_pkg.sv
rtl/bso_cmd_if.sv
rtl/bso_res_if.sv
rtl/bso_ctrl.sv
rtl/bso_datapath.sv
rtl/bitset_store_with_range_ops.sv
tb/bitset_store_with_range_ops_tb.sv
